@@ rtl/fjdr_pkg.sv @@
`default_nettype none

package fjdr_pkg;

    // Default widths of the stored time stamps and of the fault counter
    localparam int unsigned TimeWidthDef  = 32;
    localparam int unsigned FaultWidthDef = 32;

    // Configuration register indexes
    localparam logic [2:0] CfgCmdThr   = 3'd0;
    localparam logic [2:0] CfgSpdThr   = 3'd1;
    localparam logic [2:0] CfgOutThr   = 3'd2;
    localparam logic [2:0] CfgDetectMs = 3'd3;
    localparam logic [2:0] CfgRevMs    = 3'd4;
    localparam logic [2:0] CfgMaxRetry = 3'd5;
    localparam logic [2:0] CfgRevSpeed = 3'd6;

    // Drive action codes
    localparam logic [1:0] ActNormal  = 2'd0;
    localparam logic [1:0] ActReverse = 2'd1;
    localparam logic [1:0] ActZero    = 2'd2;
    localparam logic [1:0] ActLocked  = 2'd3;

    // Reported jam state codes
    localparam logic [1:0] JamIdle    = 2'd0;
    localparam logic [1:0] JamReverse = 2'd1;
    localparam logic [1:0] JamLocked  = 2'd2;

    // Internal recovery mode, one-hot
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'b001,
        MODE_REVERSE = 3'b010,
        MODE_LOCKED  = 3'b100
    } t_mode;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic               active;
        logic signed [15:0] speed_command;
        logic signed [15:0] measured_speed;
        logic signed [15:0] drive_output;
    } t_in_word;

    typedef struct packed {
        logic               override;
        logic [1:0]         drive_action;
        logic signed [15:0] drive_speed;
        logic               pid_reset;
        logic [1:0]         jam_state;
        logic [3:0]         retry_count;
        logic [31:0]        fault_count;
    } t_out_word;

    // Magnitude of a signed 16-bit value without overflow
    function automatic logic [16:0] mag16(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = {v[15], v};
        return v[15] ? 17'(-e) : 17'(e);
    endfunction

endpackage

`default_nettype wire

@@ rtl/feeder_jam_detect_and_recover.sv @@
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_stall    i_in  (t_in_word)
// out      output     o_out_valid / i_out_stall  o_out (t_out_word)
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One word per clock unless i_out_stall holds a full output register: the input
// register feeds the stall/recovery logic, whose result and state update land in the output register.
// o_out_valid rises once a word moves on from the input register, when the output is free.
// Synchronous active-low reset clears the control state, the recovery state
// and all configuration registers. The config port is always ready.
// i_out_stall holds the output register; the input register still takes a
// word while the output waits, and o_in_stall rises only when both are full.
`default_nettype none

module feeder_jam_detect_and_recover
    import fjdr_pkg::*;
#(
    parameter int unsigned TIME_WIDTH        = TimeWidthDef,
    parameter int unsigned FAULT_COUNT_WIDTH = FaultWidthDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_word    i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_word        o_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // Configuration registers
    logic [14:0]        r_cmd_thr;
    logic [14:0]        r_spd_thr;
    logic [14:0]        r_out_thr;
    logic [15:0]        r_detect_ms;
    logic [15:0]        r_rev_ms;
    logic [3:0]         r_max_retry;
    logic signed [15:0] r_rev_speed;

    // Pipeline registers
    logic      r_in_vld;
    t_in_word  r_in;
    logic      r_out_vld;
    t_out_word r_out;

    // Recovery state
    t_mode                        r_mode, n_mode;
    logic                         r_timing, n_timing;
    logic [TIME_WIDTH-1:0]        r_stall_t0, n_stall_t0;
    logic [TIME_WIDTH-1:0]        r_rev_t0, n_rev_t0;
    logic [3:0]                   r_retries, n_retries;
    logic [FAULT_COUNT_WIDTH-1:0] r_fault, n_fault;

    logic      w_out_free;
    logic      w_adv;
    t_out_word w_res;

    logic [TIME_WIDTH-1:0] w_now;
    logic [TIME_WIDTH-1:0] w_rev_elapsed;
    logic [TIME_WIDTH-1:0] w_stall_elapsed;
    logic                  w_stalled;

    // Handshake
    assign w_out_free  = !r_out_vld || !i_out_stall;
    assign w_adv       = r_in_vld && w_out_free;
    assign o_in_stall  = r_in_vld && !w_out_free;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_thr   <= '0;
            r_spd_thr   <= '0;
            r_out_thr   <= '0;
            r_detect_ms <= '0;
            r_rev_ms    <= '0;
            r_max_retry <= '0;
            r_rev_speed <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CfgCmdThr:   r_cmd_thr   <= i_cfg_data[14:0];
                CfgSpdThr:   r_spd_thr   <= i_cfg_data[14:0];
                CfgOutThr:   r_out_thr   <= i_cfg_data[14:0];
                CfgDetectMs: r_detect_ms <= i_cfg_data;
                CfgRevMs:    r_rev_ms    <= i_cfg_data;
                CfgMaxRetry: r_max_retry <= i_cfg_data[3:0];
                CfgRevSpeed: r_rev_speed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
    end

    // Elapsed times, modulo the time width
    assign w_now           = TIME_WIDTH'(r_in.now_ms);
    assign w_rev_elapsed   = w_now - r_rev_t0;
    assign w_stall_elapsed = w_now - r_stall_t0;

    // Stall condition: big command, big drive output, small measured speed
    assign w_stalled = (mag16(r_in.speed_command) >= {2'b00, r_cmd_thr})
                    && (mag16(r_in.measured_speed) <= {2'b00, r_spd_thr})
                    && (mag16(r_in.drive_output) >= {2'b00, r_out_thr});

    // Recovery logic for the word in the input register
    always_comb begin
        n_mode     = r_mode;
        n_timing   = r_timing;
        n_stall_t0 = r_stall_t0;
        n_rev_t0   = r_rev_t0;
        n_retries  = r_retries;
        n_fault    = r_fault;

        w_res              = '0;
        w_res.drive_action = ActNormal;

        if (!r_in.active) begin
            n_mode     = MODE_IDLE;
            n_timing   = 1'b0;
            n_stall_t0 = '0;
            n_rev_t0   = '0;
            n_retries  = '0;
        end else begin
            unique case (r_mode)
                MODE_LOCKED: begin
                    w_res.override     = 1'b1;
                    w_res.drive_action = ActLocked;
                end
                MODE_REVERSE: begin
                    w_res.override = 1'b1;
                    if (w_rev_elapsed < TIME_WIDTH'(r_rev_ms)) begin
                        w_res.drive_action = ActReverse;
                        w_res.drive_speed  = r_rev_speed;
                    end else begin
                        // reverse finished: hold zero and restart the loop
                        n_mode             = MODE_IDLE;
                        n_rev_t0           = '0;
                        w_res.drive_action = ActZero;
                        w_res.pid_reset    = 1'b1;
                    end
                end
                default: begin
                    if (!w_stalled) begin
                        n_timing = 1'b0;
                    end else if (!r_timing) begin
                        // first stalled tick only starts the timer
                        n_timing   = 1'b1;
                        n_stall_t0 = w_now;
                    end else if (w_stall_elapsed >= TIME_WIDTH'(r_detect_ms)) begin
                        n_timing       = 1'b0;
                        n_stall_t0     = '0;
                        w_res.override = 1'b1;
                        if (r_retries >= r_max_retry) begin
                            n_mode             = MODE_LOCKED;
                            n_fault            = r_fault + FAULT_COUNT_WIDTH'(1);
                            w_res.drive_action = ActLocked;
                        end else begin
                            n_retries          = r_retries + 4'd1;
                            n_mode             = MODE_REVERSE;
                            n_rev_t0           = w_now;
                            w_res.drive_action = ActReverse;
                            w_res.drive_speed  = r_rev_speed;
                            w_res.pid_reset    = 1'b1;
                        end
                    end
                end
            endcase
        end

        unique case (n_mode)
            MODE_REVERSE: w_res.jam_state = JamReverse;
            MODE_LOCKED:  w_res.jam_state = JamLocked;
            default:      w_res.jam_state = JamIdle;
        endcase
        w_res.retry_count = n_retries;
        w_res.fault_count = 32'(n_fault);
    end

    // State and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_timing   <= 1'b0;
            r_stall_t0 <= '0;
            r_rev_t0   <= '0;
            r_retries  <= '0;
            r_fault    <= '0;
        end else begin
            if (w_out_free) begin
                r_out_vld <= r_in_vld;
            end
            if (w_adv) begin
                r_mode     <= n_mode;
                r_timing   <= n_timing;
                r_stall_t0 <= n_stall_t0;
                r_rev_t0   <= n_rev_t0;
                r_retries  <= n_retries;
                r_fault    <= n_fault;
            end
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    // Checks
    a_stall_needs_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld))
        else $error("input stalled without both registers full");

    a_inactive_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_in.active) |=> (r_mode == MODE_IDLE && r_retries == 4'd0
                                      && !r_timing))
        else $error("inactive word did not clear recovery state");

    a_reverse_used_retry : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_REVERSE) |-> (r_retries != 4'd0))
        else $error("reversing with no retry counted");

endmodule

`default_nettype wire
